// ===== design/edp_pkg.sv =====
package edp_pkg;

	// Point capacity of the distance store and the permutation.
	localparam int PTS   = 64;
	localparam int IW    = $clog2(PTS);      // point index
	localparam int CW    = IW + 1;           // point count, holds PTS itself
	localparam int AW    = 2 * IW;           // distance store address
	localparam int DW    = 32;               // distance, Q16.16
	localparam int ACC_W = DW + AW;          // raw pair sum
	localparam int SW    = 56;               // signed sums and products
	localparam int EW    = 48;               // energy, Q32.16
	localparam int LW    = 31;               // random generator state
	localparam int REQ_W = 2;
	localparam int BLK_W = 2;
	localparam int CFG_W = 31;
	localparam int CIX_W = 2;
	localparam int N_W   = 6;                // group size registers

	localparam logic [LW-1:0] LCG_MUL = LW'(1103515245);
	localparam logic [LW-1:0] LCG_ADD = LW'(12345);

	// Request codes.
	localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
	localparam logic [REQ_W-1:0] REQ_BASE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_PERM = 2'd2;

	// Distance block codes.
	localparam logic [BLK_W-1:0] BLK_11 = 2'd0;
	localparam logic [BLK_W-1:0] BLK_12 = 2'd1;
	localparam logic [BLK_W-1:0] BLK_22 = 2'd2;

	// Configuration register indexes.
	localparam logic [CIX_W-1:0] CFG_N1   = 2'd0;
	localparam logic [CIX_W-1:0] CFG_N2   = 2'd1;
	localparam logic [CIX_W-1:0] CFG_SEED = 2'd2;

	typedef struct packed {
		logic          start;
		logic          short_mode;   // LW-bit dividend, remainder only
		logic [SW-1:0] dividend;
		logic [CW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic          done;
		logic [SW-1:0] quotient;
		logic [CW-1:0] remainder;
	} div_rsp_t;

endpackage

// ===== design/edp_ram.sv =====
module edp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/edp_div.sv =====
module edp_div (
	input  logic               clk,
	input  logic               arst_n,
	input  edp_pkg::div_req_t  req,
	output edp_pkg::div_rsp_t  rsp
);
	import edp_pkg::*;

	localparam int CNT_W = $clog2(SW + 1);

	logic [SW-1:0]    quo_q;
	logic [CW-1:0]    rem_q;
	logic [CW-1:0]    div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [CW:0]      trial;
	logic             ge;

	// One quotient bit per cycle: shift in the next dividend bit, subtract if it fits.
	assign trial = {rem_q, quo_q[SW-1]};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (req.start) begin
				cnt_q <= req.short_mode ? CNT_W'(LW) : CNT_W'(SW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.short_mode ? {req.dividend[LW-1:0], {(SW-LW){1'b0}}} : req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[SW-2:0], ge};
			rem_q <= ge ? CW'(trial - {1'b0, div_q}) : CW'(trial);
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

// ===== design/energy_distance_permutation.sv =====
// Load: one store write, a second for a cross-block entry (mirrored write); no result.
// Baseline: one distance store read per pair over all three blocks, then three passes of
// the bit-serial divider before the strobe.
// Permute: a shuffle with one divider pass per draw, then the intra pairs and the three
// divider passes. busy holds until the strobe: one request at a time.
// Reset: async, control cleared, permutation identity, generator and total zero; no stall.
module energy_distance_permutation (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [edp_pkg::CIX_W-1:0]     cfg_idx,
	input  logic [edp_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          start,
	output logic                          busy,
	input  logic [edp_pkg::REQ_W-1:0]     req_type,
	input  logic [edp_pkg::BLK_W-1:0]     block,
	input  logic [edp_pkg::IW-1:0]        row,
	input  logic [edp_pkg::IW-1:0]        col,
	input  logic [edp_pkg::DW-1:0]        distance,
	output logic                          done,
	output logic signed [edp_pkg::EW-1:0] energy,
	output logic                          is_original
);
	import edp_pkg::*;

	typedef enum logic [18:0] {
		S_IDLE    = 19'h00001,
		S_LOAD2   = 19'h00002,
		S_SUM     = 19'h00004,
		S_SH_LCG  = 19'h00008,
		S_SH_GO   = 19'h00010,
		S_SH_WAIT = 19'h00020,
		S_SH_RD   = 19'h00040,
		S_SH_W1   = 19'h00080,
		S_SH_W2   = 19'h00100,
		S_EN_INIT = 19'h00200,
		S_EN_M1   = 19'h00400,
		S_EN_D1G  = 19'h00800,
		S_EN_D1W  = 19'h01000,
		S_EN_M2   = 19'h02000,
		S_EN_D2G  = 19'h04000,
		S_EN_D2W  = 19'h08000,
		S_EN_X    = 19'h10000,
		S_EN_D3G  = 19'h20000,
		S_EN_D3W  = 19'h40000
	} state_t;

	typedef enum logic [1:0] {
		PH_INTER  = 2'd0,
		PH_INTRA1 = 2'd1,
		PH_INTRA2 = 2'd2
	} phase_t;

	localparam logic signed [SW-1:0] E_MAX = {{(SW-EW+1){1'b0}}, {(EW-1){1'b1}}};
	localparam logic signed [SW-1:0] E_MIN = {{(SW-EW+1){1'b1}}, {(EW-1){1'b0}}};

	state_t state_q;
	phase_t ph_q;

	// configuration
	logic [N_W-1:0] g1_q, g2_q;
	logic [LW-1:0]  seed_q;

	// effective group sizes
	logic [CW-1:0] n1, n2, n_all, lim2, n1c, n2c;

	// pair iterator
	logic [CW-1:0] i_q, j_q, iend_q, jlim;
	logic [IW-1:0] rbase_q, cbase_q, a_pos, b_pos;
	logic          inter_mode_q, more_q, issue;

	// pair pipeline
	logic          v_s1, v_s2;
	logic          sel_a_s1, sel_b_s1;
	logic [IW-1:0] pos_a_s1, pos_b_s1;
	logic [IW-1:0] ram_a, ram_b, pv_a, pv_b;
	logic [DW-1:0] dist_rd;
	logic [ACC_W-1:0] acc_q;
	logic [SW-1:0]    dbl;

	// permutation
	logic [PTS-1:0] pvalid_q;
	logic           p_we;
	logic [IW-1:0]  p_waddr, p_wdata, swap_q;

	// distance store write side
	logic           acc_in, ld_ok, ld_mirror, d_we;
	logic [AW-1:0]  ld_addr, mir_q, d_waddr;
	logic [DW-1:0]  dist_q, d_wdata;
	logic [IW-1:0]  cpos, rpos2, cpos2;

	// energy arithmetic
	logic [LW-1:0]  lcg_q;
	logic signed [SW-1:0] total_q, inter_q, intra1_q, intra2_q;
	logic signed [SW-1:0] t1_q, t2_q, xdiff, q_s;
	logic [SW-1:0]  prod_q;
	logic           neg_q, base_q, done_q;
	logic signed [EW-1:0] energy_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	// Clamp the group sizes so that both groups fit the store.
	always_comb begin
		n1c   = (CW'(g1_q) > CW'(PTS - 1)) ? CW'(PTS - 1) : CW'(g1_q);
		n1    = (n1c == '0) ? CW'(1) : n1c;
		lim2  = CW'(PTS) - n1;
		n2c   = (CW'(g2_q) > lim2) ? lim2 : CW'(g2_q);
		n2    = (n2c == '0) ? CW'(1) : n2c;
		n_all = n1 + n2;
	end

	assign busy   = (state_q != S_IDLE);
	assign acc_in = start && !busy;

	// Decode a load into its global store position.
	always_comb begin
		cpos      = IW'(n1) + col;
		rpos2     = IW'(n1) + row;
		cpos2     = IW'(n1) + col;
		ld_ok     = 1'b0;
		ld_mirror = 1'b0;
		ld_addr   = {row, col};
		unique case (block)
			BLK_11: begin
				ld_ok = (CW'(row) < n1) && (CW'(col) < n1);
			end
			BLK_12: begin
				ld_ok     = (CW'(row) < n1) && (CW'(col) < n2);
				ld_mirror = 1'b1;
				ld_addr   = {row, cpos};
			end
			BLK_22: begin
				ld_ok   = (CW'(row) < n2) && (CW'(col) < n2);
				ld_addr = {rpos2, cpos2};
			end
			default: ld_ok = 1'b0;
		endcase
	end

	assign d_we    = (acc_in && req_type == REQ_LOAD && ld_ok) || (state_q == S_LOAD2);
	assign d_waddr = (state_q == S_LOAD2) ? mir_q : ld_addr;
	assign d_wdata = (state_q == S_LOAD2) ? dist_q : distance;

	// Positions of the current pair; in the shuffle the bases are zero, so these are i and j.
	assign a_pos = rbase_q + i_q[IW-1:0];
	assign b_pos = cbase_q + j_q[IW-1:0];
	assign jlim  = inter_mode_q ? n2 : i_q;
	assign issue = (state_q == S_SUM) && more_q;

	// An entry never written since the last baseline reads as its own index.
	assign pv_a = sel_a_s1 ? ram_a : pos_a_s1;
	assign pv_b = sel_b_s1 ? ram_b : pos_b_s1;

	assign dbl = SW'({acc_q, 1'b0});

	assign p_we    = (state_q == S_SH_W1) || (state_q == S_SH_W2);
	assign p_waddr = (state_q == S_SH_W1) ? i_q[IW-1:0] : j_q[IW-1:0];
	assign p_wdata = (state_q == S_SH_W1) ? pv_b : swap_q;

	assign xdiff = inter_q - t1_q - t2_q;
	assign q_s   = neg_q ? -$signed(div_rsp.quotient) : $signed(div_rsp.quotient);

	// Hand the shared divider its operands in the go states.
	always_comb begin
		div_req            = '0;
		div_req.dividend   = prod_q;
		div_req.divisor    = n1;
		unique case (state_q)
			S_SH_GO: begin
				div_req.start      = 1'b1;
				div_req.short_mode = 1'b1;
				div_req.dividend   = SW'(lcg_q);
				div_req.divisor    = i_q + CW'(1);
			end
			S_EN_D1G: div_req.start = 1'b1;
			S_EN_D2G: begin
				div_req.start   = 1'b1;
				div_req.divisor = n2;
			end
			S_EN_D3G: begin
				div_req.start   = 1'b1;
				div_req.divisor = n_all;
			end
			default: div_req.start = 1'b0;
		endcase
	end

	edp_ram #(.WIDTH(DW), .DEPTH(PTS * PTS)) u_dist (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.raddr ({pv_a, pv_b}),
		.rdata (dist_rd)
	);

	// Two copies of the permutation give two reads a cycle.
	edp_ram #(.WIDTH(IW), .DEPTH(PTS)) u_perm_a (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (a_pos),
		.rdata (ram_a)
	);

	edp_ram #(.WIDTH(IW), .DEPTH(PTS)) u_perm_b (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (b_pos),
		.rdata (ram_b)
	);

	edp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g1_q   <= N_W'(1);
			g2_q   <= N_W'(1);
			seed_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_N1:   g1_q   <= cfg_data[N_W-1:0];
				CFG_N2:   g2_q   <= cfg_data[N_W-1:0];
				CFG_SEED: seed_q <= cfg_data[LW-1:0];
				default:  ;
			endcase
		end
	end

	// Pair pipeline: permutation read, then store read, then accumulate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sel_a_s1 <= pvalid_q[a_pos];
		sel_b_s1 <= pvalid_q[b_pos];
		pos_a_s1 <= a_pos;
		pos_b_s1 <= b_pos;
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ph_q     <= PH_INTER;
			more_q   <= 1'b0;
			pvalid_q <= '0;
			lcg_q    <= '0;
			total_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (issue) begin
				// advance to the next pair
				if (j_q + CW'(1) < jlim) begin
					j_q <= j_q + CW'(1);
				end else begin
					j_q <= '0;
					i_q <= i_q + CW'(1);
					if (i_q + CW'(1) >= iend_q) begin
						more_q <= 1'b0;
					end
				end
			end
			if (v_s2) begin
				acc_q <= acc_q + ACC_W'(dist_rd);
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc_in) begin
						unique case (req_type)
							REQ_LOAD: begin
								mir_q  <= {ld_addr[IW-1:0], ld_addr[AW-1:IW]};
								dist_q <= distance;
								if (ld_ok && ld_mirror) begin
									state_q <= S_LOAD2;
								end
							end
							REQ_BASE: begin
								pvalid_q     <= '0;
								lcg_q        <= seed_q;
								base_q       <= 1'b1;
								ph_q         <= PH_INTER;
								rbase_q      <= '0;
								cbase_q      <= IW'(n1);
								i_q          <= '0;
								j_q          <= '0;
								iend_q       <= n1;
								inter_mode_q <= 1'b1;
								more_q       <= 1'b1;
								acc_q        <= '0;
								state_q      <= S_SUM;
							end
							REQ_PERM: begin
								base_q  <= 1'b0;
								rbase_q <= '0;
								cbase_q <= '0;
								i_q     <= n_all - CW'(1);
								state_q <= S_SH_LCG;
							end
							default: ;
						endcase
					end
				end
				S_LOAD2: state_q <= S_IDLE;
				S_SH_LCG: begin
					lcg_q   <= lcg_q * LCG_MUL + LCG_ADD;
					state_q <= S_SH_GO;
				end
				S_SH_GO: state_q <= S_SH_WAIT;
				S_SH_WAIT: begin
					if (div_rsp.done) begin
						j_q     <= div_rsp.remainder;
						state_q <= S_SH_RD;
					end
				end
				S_SH_RD: state_q <= S_SH_W1;
				S_SH_W1: begin
					swap_q                   <= pv_a;
					pvalid_q[i_q[IW-1:0]]    <= 1'b1;
					state_q                  <= S_SH_W2;
				end
				S_SH_W2: begin
					pvalid_q[j_q[IW-1:0]] <= 1'b1;
					if (i_q == '0) begin
						ph_q         <= PH_INTRA1;
						rbase_q      <= '0;
						cbase_q      <= '0;
						i_q          <= CW'(1);
						j_q          <= '0;
						iend_q       <= n1;
						inter_mode_q <= 1'b0;
						more_q       <= CW'(1) < n1;
						acc_q        <= '0;
						state_q      <= S_SUM;
					end else begin
						i_q     <= i_q - CW'(1);
						state_q <= S_SH_LCG;
					end
				end
				S_SUM: begin
					// hold until the last pair has left the pipeline
					if (!more_q && !v_s1 && !v_s2) begin
						unique case (ph_q)
							PH_INTER: begin
								inter_q      <= dbl;
								ph_q         <= PH_INTRA1;
								rbase_q      <= '0;
								cbase_q      <= '0;
								i_q          <= CW'(1);
								j_q          <= '0;
								iend_q       <= n1;
								inter_mode_q <= 1'b0;
								more_q       <= CW'(1) < n1;
								acc_q        <= '0;
							end
							PH_INTRA1: begin
								intra1_q     <= dbl;
								ph_q         <= PH_INTRA2;
								rbase_q      <= IW'(n1);
								cbase_q      <= IW'(n1);
								i_q          <= CW'(1);
								j_q          <= '0;
								iend_q       <= n2;
								inter_mode_q <= 1'b0;
								more_q       <= CW'(1) < n2;
								acc_q        <= '0;
							end
							PH_INTRA2: begin
								intra2_q <= dbl;
								state_q  <= S_EN_INIT;
							end
							default: state_q <= S_EN_INIT;
						endcase
					end
				end
				S_EN_INIT: begin
					if (base_q) begin
						total_q <= inter_q + intra1_q + intra2_q;
					end else begin
						inter_q <= total_q - intra1_q - intra2_q;
					end
					state_q <= S_EN_M1;
				end
				S_EN_M1: begin
					prod_q  <= SW'(n2 * intra1_q[ACC_W:0]);
					state_q <= S_EN_D1G;
				end
				S_EN_D1G: state_q <= S_EN_D1W;
				S_EN_D1W: begin
					if (div_rsp.done) begin
						t1_q    <= $signed(div_rsp.quotient);
						state_q <= S_EN_M2;
					end
				end
				S_EN_M2: begin
					prod_q  <= SW'(n1 * intra2_q[ACC_W:0]);
					state_q <= S_EN_D2G;
				end
				S_EN_D2G: state_q <= S_EN_D2W;
				S_EN_D2W: begin
					if (div_rsp.done) begin
						t2_q    <= $signed(div_rsp.quotient);
						state_q <= S_EN_X;
					end
				end
				S_EN_X: begin
					// divide the magnitude, restore the sign after
					neg_q   <= xdiff[SW-1];
					prod_q  <= xdiff[SW-1] ? SW'(-xdiff) : SW'(xdiff);
					state_q <= S_EN_D3G;
				end
				S_EN_D3G: state_q <= S_EN_D3W;
				S_EN_D3W: begin
					if (div_rsp.done) begin
						priority if (q_s > E_MAX) begin
							energy_q <= E_MAX[EW-1:0];
						end else if (q_s < E_MIN) begin
							energy_q <= E_MIN[EW-1:0];
						end else begin
							energy_q <= q_s[EW-1:0];
						end
						is_original <= base_q;
						done_q      <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign energy = energy_q;

`ifndef SYNTH
	// A result transfer comes only out of the final division.
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_EN_D3W))
		else $error("result strobe without final division");

	// Energy requests take the block busy on the next cycle.
	a_busy_req: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_in && (req_type == REQ_BASE || req_type == REQ_PERM)) |=> busy)
		else $error("energy request did not start");

	// Pair reads only drain inside a sum phase.
	a_pipe_sum: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (state_q == S_SUM))
		else $error("pair pipeline active outside sum");

	// A baseline request restores the identity permutation.
	a_base_ident: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_in && req_type == REQ_BASE) |=> (pvalid_q == '0))
		else $error("permutation not reset on baseline");
`endif

endmodule

// ===== verif/testbench.sv =====
module testbench;
	import edp_pkg::*;

	// Settle time after the last transfer before a register write or the verdict.
	localparam int SETTLE = 8;

	typedef struct {
		logic [REQ_W-1:0] req;
		logic [BLK_W-1:0] blk;
		logic [IW-1:0]    row;
		logic [IW-1:0]    col;
		logic [DW-1:0]    dval;
		bit               typed;     // expected energy written in the row
		logic [EW-1:0]    typed_e;
		bit               typed_o;
	} req_item_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CIX_W-1:0]     cfg_idx;
	logic [CFG_W-1:0]     cfg_data;
	logic                 start;
	logic                 busy;
	logic [REQ_W-1:0]     req_type;
	logic [BLK_W-1:0]     block;
	logic [IW-1:0]        row;
	logic [IW-1:0]        col;
	logic [DW-1:0]        distance;
	logic                 done;
	logic signed [EW-1:0] energy;
	logic                 is_original;

	energy_distance_permutation u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.start(start), .busy(busy),
		.req_type(req_type), .block(block), .row(row), .col(col), .distance(distance),
		.done(done), .energy(energy), .is_original(is_original)
	);

	// Shadow of the block state: distance store with a written map, point order,
	// generator, kept pair total and the three registers.
	logic [DW-1:0] dist_mem [PTS*PTS];
	bit            dist_set [PTS*PTS];
	int            point_order [PTS];
	logic [LW-1:0] gen_state;
	longint        pair_total;
	int            reg_n1, reg_n2;
	logic [LW-1:0] reg_seed;

	logic [EW-1:0] energy_q [$];
	bit            origin_q [$];
	int            errors;
	bit            no_gaps;

	function automatic int size_one();
		int n;
		n = reg_n1;
		if (n > PTS - 1) n = PTS - 1;
		if (n < 1) n = 1;
		return n;
	endfunction

	function automatic int size_two(int n1);
		int n;
		n = reg_n2;
		if (n > PTS - n1) n = PTS - n1;
		if (n < 1) n = 1;
		return n;
	endfunction

	function automatic longint dist_at(int a, int b);
		return longint'({32'd0, dist_mem[(point_order[a % PTS] % PTS) * PTS
			+ (point_order[b % PTS] % PTS)]});
	endfunction

	// Doubled sum over position pairs inside one group.
	function automatic longint group_sum(int base, int n);
		longint s;
		s = 0;
		for (int i = 1; i < n; i++)
			for (int j = 0; j < i; j++)
				s += dist_at(base + i, base + j);
		return s * 2;
	endfunction

	function automatic longint cross_sum(int n1, int n2);
		longint s;
		s = 0;
		for (int i = 0; i < n1; i++)
			for (int j = 0; j < n2; j++)
				s += dist_at(i, n1 + j);
		return s * 2;
	endfunction

	function automatic logic [EW-1:0] energy_from(longint inter, longint in1, longint in2,
			int n1, int n2);
		longint t1, t2, e;
		t1 = (longint'(n2) * in1) / longint'(n1);
		t2 = (longint'(n1) * in2) / longint'(n2);
		e = (inter - t1 - t2) / longint'(n1 + n2);
		if (e > 64'sh7FFF_FFFF_FFFF) e = 64'sh7FFF_FFFF_FFFF;
		if (e < -64'sh8000_0000_0000) e = -64'sh8000_0000_0000;
		return e[EW-1:0];
	endfunction

	function automatic void store_dist(int a, int b, logic [DW-1:0] d);
		dist_mem[a * PTS + b] = d;
		dist_set[a * PTS + b] = 1'b1;
	endfunction

	// Advance the shadow state by one accepted request; return whether it yields energy.
	function automatic bit predict_energy(req_item_t it, output logic [EW-1:0] e,
			output bit orig);
		int n1, n2, j, t;
		longint inter, in1, in2;
		logic [63:0] prod;
		n1 = size_one();
		n2 = size_two(n1);
		e = '0;
		orig = 1'b0;
		case (it.req)
			REQ_LOAD: begin
				if (it.blk == BLK_11 && it.row < n1 && it.col < n1)
					store_dist(it.row, it.col, it.dval);
				else if (it.blk == BLK_12 && it.row < n1 && it.col < n2) begin
					store_dist(it.row, n1 + it.col, it.dval);
					store_dist(n1 + it.col, it.row, it.dval);
				end else if (it.blk == BLK_22 && it.row < n2 && it.col < n2)
					store_dist(n1 + it.row, n1 + it.col, it.dval);
				return 1'b0;
			end
			REQ_BASE: begin
				for (int k = 0; k < PTS; k++) point_order[k] = k;
				gen_state = reg_seed;
				inter = cross_sum(n1, n2);
				in1 = group_sum(0, n1);
				in2 = group_sum(n1, n2);
				pair_total = inter + in1 + in2;
				orig = 1'b1;
			end
			REQ_PERM: begin
				for (int i = n1 + n2 - 1; i >= 0; i--) begin
					prod = 64'(gen_state) * 64'd1103515245 + 64'd12345;
					gen_state = prod[LW-1:0];
					j = int'({1'b0, gen_state} % (i + 1));
					t = point_order[i];
					point_order[i] = point_order[j];
					point_order[j] = t;
				end
				in1 = group_sum(0, n1);
				in2 = group_sum(n1, n2);
				inter = pair_total - in1 - in2;
			end
			default: return 1'b0;
		endcase
		e = energy_from(inter, in1, in2, n1, n2);
		return 1'b1;
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("** energy_distance_permutation: FAILED **");
		$finish;
	end

	// Check every strobed result against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (energy_q.size() == 0) begin
				$error("unexpected result: energy %h is_original %b", energy, is_original);
				errors++;
			end else begin
				logic [EW-1:0] exp_e;
				bit exp_o;
				exp_e = energy_q.pop_front();
				exp_o = origin_q.pop_front();
				if (energy !== exp_e) begin
					$error("energy: expected %h, actual %h", exp_e, energy);
					errors++;
				end
				if (is_original !== exp_o) begin
					$error("is_original: expected %b, actual %b", exp_o, is_original);
					errors++;
				end
			end
		end
	end

	// Hold start high until the block takes the request, then log the expectation.
	task automatic transfer(req_item_t it);
		logic [EW-1:0] e;
		bit o;
		while (!no_gaps && $urandom_range(99) < 35) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start    <= 1'b1;
		req_type <= it.req;
		block    <= it.blk;
		row      <= it.row;
		col      <= it.col;
		distance <= it.dval;
		do @(posedge clk); while (busy);
		if (predict_energy(it, e, o)) begin
			energy_q.push_back(it.typed ? it.typed_e : e);
			origin_q.push_back(it.typed ? it.typed_o : o);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (energy_q.size() != 0 || busy) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CIX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_N1:   reg_n1 = int'(val[N_W-1:0]);
			CFG_N2:   reg_n2 = int'(val[N_W-1:0]);
			CFG_SEED: reg_seed = val[LW-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_sizes(int n1, int n2, logic [LW-1:0] s);
		drain();
		write_reg(CFG_N1, CFG_W'(n1));
		write_reg(CFG_N2, CFG_W'(n2));
		write_reg(CFG_SEED, CFG_W'(s));
	endtask

	function automatic logic [DW-1:0] rand_dist();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return DW'($urandom_range(65535));
			default: return $urandom();
		endcase
	endfunction

	function automatic req_item_t load_item(int b, int r, int c, logic [DW-1:0] d);
		req_item_t it;
		it = '{REQ_LOAD, BLK_W'(b), IW'(r), IW'(c), d, 1'b0, '0, 1'b0};
		return it;
	endfunction

	// Write every off-diagonal pair among the active points that is still blank,
	// so no request can read an entry that was never written.
	task automatic fill_store();
		int n1, n2, nt;
		n1 = size_one();
		n2 = size_two(n1);
		nt = n1 + n2;
		for (int a = 0; a < nt; a++)
			for (int b = 0; b < nt; b++) begin
				if (a == b || dist_set[a * PTS + b]) continue;
				if (a < n1 && b < n1)
					transfer(load_item(BLK_11, a, b, rand_dist()));
				else if (a >= n1 && b >= n1)
					transfer(load_item(BLK_22, a - n1, b - n1, rand_dist()));
				else if (a < n1)
					transfer(load_item(BLK_12, a, b - n1, rand_dist()));
				else
					transfer(load_item(BLK_12, b, a - n1, rand_dist()));
			end
	endtask

	function automatic req_item_t random_item();
		req_item_t it;
		int n1, n2, p;
		n1 = size_one();
		n2 = size_two(n1);
		it = load_item(BLK_11, 0, 0, rand_dist());
		p = $urandom_range(99);
		if (p < 15)
			it.req = REQ_BASE;
		else if (p < 40)
			it.req = REQ_PERM;
		else if (p < 80) begin
			// well-formed load inside the active groups
			it.blk = BLK_W'($urandom_range(2));
			case (it.blk)
				BLK_11: begin
					it.row = IW'($urandom_range(n1 - 1));
					it.col = IW'($urandom_range(n1 - 1));
				end
				BLK_12: begin
					it.row = IW'($urandom_range(n1 - 1));
					it.col = IW'($urandom_range(n2 - 1));
				end
				default: begin
					it.row = IW'($urandom_range(n2 - 1));
					it.col = IW'($urandom_range(n2 - 1));
				end
			endcase
		end else begin
			// noise: unknown request, bad block, or any index at all
			it.req = ($urandom_range(3) == 0) ? REQ_W'(3) : REQ_LOAD;
			it.blk = BLK_W'($urandom_range(3));
			it.row = IW'($urandom());
			it.col = IW'($urandom());
		end
		if ($urandom_range(3) == 0) begin
			it.row = IW'($urandom());
			it.col = IW'($urandom());
		end
		return it;
	endfunction

	// Directed rows at one point per group. The cross-block entry is the only stored
	// pair read, so the energies follow at a glance.
	req_item_t directed [] = '{
		'{REQ_LOAD, BLK_12, 6'd0, 6'd0, 32'hFFFF_FFFF, 1'b0, 48'd0, 1'b0},
		// permute before any baseline: total is zero, both groups are single
		'{REQ_PERM, BLK_11, 6'd0, 6'd0, 32'd0, 1'b1, 48'd0, 1'b0},
		'{REQ_BASE, BLK_11, 6'd0, 6'd0, 32'd0, 1'b1, 48'h0000_FFFF_FFFF, 1'b1},
		// ignored loads: bad block, index out of group
		'{REQ_LOAD, BLK_W'(3), 6'd0, 6'd0, 32'd0, 1'b0, 48'd0, 1'b0},
		'{REQ_LOAD, BLK_12, 6'd63, 6'd0, 32'd0, 1'b0, 48'd0, 1'b0},
		'{REQ_LOAD, BLK_12, 6'd0, 6'd63, 32'd0, 1'b0, 48'd0, 1'b0},
		'{REQ_LOAD, BLK_11, 6'd63, 6'd63, 32'd0, 1'b0, 48'd0, 1'b0},
		'{REQ_LOAD, BLK_22, 6'd0, 6'd63, 32'd0, 1'b0, 48'd0, 1'b0},
		// unknown request: no result
		'{REQ_W'(3), BLK_W'(3), 6'd63, 6'd63, 32'hFFFF_FFFF, 1'b0, 48'd0, 1'b0},
		// diagonal entries are never read
		'{REQ_LOAD, BLK_11, 6'd0, 6'd0, 32'h1234_5678, 1'b0, 48'd0, 1'b0},
		'{REQ_LOAD, BLK_22, 6'd0, 6'd0, 32'hFFFF_FFFF, 1'b0, 48'd0, 1'b0},
		'{REQ_BASE, BLK_11, 6'd0, 6'd0, 32'd0, 1'b1, 48'h0000_FFFF_FFFF, 1'b1},
		'{REQ_PERM, BLK_11, 6'd0, 6'd0, 32'd0, 1'b1, 48'h0000_FFFF_FFFF, 1'b0},
		'{REQ_LOAD, BLK_12, 6'd0, 6'd0, 32'd0, 1'b0, 48'd0, 1'b0},
		'{REQ_BASE, BLK_11, 6'd0, 6'd0, 32'd0, 1'b1, 48'd0, 1'b1},
		'{REQ_PERM, BLK_11, 6'd0, 6'd0, 32'd0, 1'b0, 48'd0, 1'b0}
	};

	int phase_n1 [] = '{0, 3, 5, 2, 1, 4};
	int phase_n2 [] = '{0, 2, 3, 6, 7, 1};

	initial begin
		arst_n   = 1'b0;
		cfg_we   = 1'b0;
		cfg_idx  = '0;
		cfg_data = '0;
		start    = 1'b0;
		req_type = '0;
		block    = '0;
		row      = '0;
		col      = '0;
		distance = '0;
		errors   = 0;
		no_gaps  = 1'b0;
		for (int k = 0; k < PTS * PTS; k++) begin
			dist_mem[k] = '0;
			dist_set[k] = 1'b0;
		end
		for (int k = 0; k < PTS; k++) point_order[k] = k;
		gen_state  = '0;
		pair_total = 0;
		reg_n1     = 1;
		reg_n2     = 1;
		reg_seed   = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[k]) transfer(directed[k]);

		// Walk the size settings; random content, with one gap-free stretch.
		foreach (phase_n1[p]) begin
			set_sizes(phase_n1[p], phase_n2[p],
				(p == 0) ? 31'h7FFF_FFFF : LW'($urandom()));
			fill_store();
			for (int k = 0; k < 40; k++) begin
				no_gaps = (p == 2);
				transfer(random_item());
			end
			no_gaps = 1'b0;
		end

		drain();
		repeat (40) @(posedge clk);
		if (errors == 0 && energy_q.size() == 0)
			$display("** energy_distance_permutation: PASSED **");
		else
			$display("** energy_distance_permutation: FAILED **");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/edp_pkg.sv
design/edp_ram.sv
design/edp_div.sv
design/energy_distance_permutation.sv
verif/testbench.sv
